// ===== rtl/spr_pkg.sv =====
package spr_pkg;

  localparam int unsigned VerticesDef  = 8;
  localparam int unsigned DistWidthDef = 16;

  localparam int unsigned IdxW     = 3;
  localparam int unsigned PredW    = 3;
  localparam int unsigned OutDistW = 16;
  localparam int unsigned CntW     = 7;
  localparam int unsigned VcountW  = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 4;

  localparam logic [CfgIdxW-1:0] CfgPivot  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgVcount = 1'b1;

  typedef enum logic [1:0] {
    FuncLoad = 2'd0,
    FuncPass = 2'd1,
    FuncRead = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    StIdle,
    StPassIk,
    StPassRun,
    StRdWait,
    StResp
  } state_e;

endpackage

// ===== rtl/shortest_path_pivot_relax.sv =====
// one relaxation step of all-pairs shortest paths through a pivot vertex k. the block keeps
// a VERTICES x VERTICES matrix of distances with infinity flags and predecessors with nil
// flags in a two-read-port memory that is not cleared at reset: load every entry before it
// is read or used by a pass. func 0 loads one entry (result word of zeros), func 2 reads one
// entry, func 1 relaxes every entry with row and column below vertex_count through
// pivot_vertex and returns the number of improved entries. a pass walks the entries row by
// row through one shared adder and comparator: per row it first fetches d[i][k], then works
// through the entries of the row one at a time, then drains. one item is in work at a time;
// a finished result waits in the output register while the next word is taken.
module shortest_path_pivot_relax #(
  parameter int unsigned VERTICES   = spr_pkg::VerticesDef,
  parameter int unsigned DIST_WIDTH = spr_pkg::DistWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [3:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  input  logic [2:0]          row_i,
  input  logic [2:0]          col_i,
  input  logic signed [15:0]  dist_value_i,
  input  logic                dist_inf_i,
  input  logic [2:0]          pred_value_i,
  input  logic                pred_nil_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  dist_out_o,
  output logic                dist_inf_out_o,
  output logic [2:0]          pred_out_o,
  output logic                pred_nil_out_o,
  output logic [6:0]          improved_count_o
);

  import spr_pkg::*;

  localparam int unsigned DW = DIST_WIDTH;
  localparam int unsigned RB = $clog2(VERTICES);
  localparam int unsigned CW = $clog2(VERTICES + 1);
  localparam int unsigned AW = 2 * RB;
  localparam int unsigned EW = DW + PredW + 2;
  localparam logic [VcountW-1:0] VtxLim = VcountW'(VERTICES);
  localparam logic [CW-1:0]      VtxLimC = CW'(VERTICES);

  // entry layout: dist, inf, pred, nil
  localparam int unsigned PosInf  = PredW + 1;
  localparam int unsigned PosPred = 1;

  state_e state_q, state_d;

  logic [IdxW-1:0]    pivot_q;
  logic [VcountW-1:0] vcount_q;

  logic [CW-1:0]      i_q, i_d, j_q, j_d, n_q, n_d;
  logic               ex_vld_q, ex_vld_d;
  logic [RB-1:0]      ex_j_q, ex_j_d;
  logic               ik_ld_q, ik_ld_d;
  logic               rd_ok_q, rd_ok_d;
  logic signed [DW-1:0] ik_dist_q, ik_dist_d;
  logic               ik_inf_q, ik_inf_d;

  logic signed [OutDistW-1:0] res_dist_q, res_dist_d;
  logic               res_inf_q, res_inf_d;
  logic [PredW-1:0]   res_pred_q, res_pred_d;
  logic               res_nil_q, res_nil_d;
  logic [CntW-1:0]    res_cnt_q, res_cnt_d;

  logic               out_vld_q, out_vld_d;
  logic               out_load;
  logic signed [OutDistW-1:0] out_dist_q;
  logic               out_inf_q;
  logic [PredW-1:0]   out_pred_q;
  logic               out_nil_q;
  logic [CntW-1:0]    out_cnt_q;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [EW-1:0]      mem_wdata, rdata_a, rdata_b;

  logic               accept, in_range, pass_skip;
  logic [VcountW-1:0] n_eff;
  logic               improve;
  logic signed [DW-1:0] sum;
  logic signed [DW-1:0] a_dist, b_dist;
  logic               a_inf, b_inf;
  logic [PredW-1:0]   b_pred;
  logic               b_nil;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_q  <= '0;
      vcount_q <= VcountW'(8);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPivot:  pivot_q  <= cfg_data_i[IdxW-1:0];
        CfgVcount: vcount_q <= cfg_data_i[VcountW-1:0];
        default:   ;
      endcase
    end
  end

  assign accept    = in_valid_i && in_ready_o;
  assign in_range  = ({1'b0, row_i} < VtxLim) && ({1'b0, col_i} < VtxLim);
  assign n_eff     = (vcount_q > VtxLim) ? VtxLim : vcount_q;
  assign pass_skip = (n_eff == '0) || ({1'b0, pivot_q} >= VtxLim);

  assign a_dist = rdata_a[EW-1 -: DW];
  assign a_inf  = rdata_a[PosInf];
  assign b_dist = rdata_b[EW-1 -: DW];
  assign b_inf  = rdata_b[PosInf];
  assign b_pred = rdata_b[PosPred +: PredW];
  assign b_nil  = rdata_b[0];

  spr_mem #(
    .AW (AW),
    .EW (EW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  spr_alu #(
    .DW (DW)
  ) u_alu (
    .ik_dist_i (ik_dist_q),
    .ik_inf_i  (ik_inf_q),
    .kj_dist_i (b_dist),
    .kj_inf_i  (b_inf),
    .ij_dist_i (a_dist),
    .ij_inf_i  (a_inf),
    .improve_o (improve),
    .sum_o     (sum)
  );

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    n_d        = n_q;
    ex_vld_d   = 1'b0;
    ex_j_d     = ex_j_q;
    ik_ld_d    = 1'b0;
    rd_ok_d    = rd_ok_q;
    ik_dist_d  = ik_dist_q;
    ik_inf_d   = ik_inf_q;
    res_dist_d = res_dist_q;
    res_inf_d  = res_inf_q;
    res_pred_d = res_pred_q;
    res_nil_d  = res_nil_q;
    res_cnt_d  = res_cnt_q;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = {i_q[RB-1:0], ex_j_q};
    mem_wdata  = {sum, 1'b0, b_pred, b_nil};
    mem_raddr_a = {i_q[RB-1:0], j_q[RB-1:0]};
    mem_raddr_b = {pivot_q[RB-1:0], j_q[RB-1:0]};

    case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        mem_raddr_a = {row_i[RB-1:0], col_i[RB-1:0]};
        if (accept) begin
          res_dist_d = '0;
          res_inf_d  = 1'b0;
          res_pred_d = '0;
          res_nil_d  = 1'b0;
          res_cnt_d  = '0;
          rd_ok_d    = in_range;
          case (func_i)
            FuncLoad: begin
              mem_we    = in_range;
              mem_waddr = {row_i[RB-1:0], col_i[RB-1:0]};
              mem_wdata = {DW'(dist_value_i), dist_inf_i, pred_value_i, pred_nil_i};
              state_d   = StResp;
            end
            FuncPass: begin
              i_d     = '0;
              n_d     = (n_eff >= VcountW'(VtxLimC)) ? VtxLimC : CW'(n_eff);
              state_d = pass_skip ? StResp : StPassIk;
            end
            FuncRead: begin
              state_d = StRdWait;
            end
            default: begin
              state_d = StResp;
            end
          endcase
        end
      end
      StPassIk: begin
        mem_raddr_a = {i_q[RB-1:0], pivot_q[RB-1:0]};
        j_d         = '0;
        ik_ld_d     = 1'b1;
        state_d     = StPassRun;
      end
      StPassRun: begin
        if (ik_ld_q) begin
          ik_dist_d = a_dist;
          ik_inf_d  = a_inf;
        end
        if (ex_vld_q && improve) begin
          mem_we    = 1'b1;
          res_cnt_d = res_cnt_q + CntW'(1);
          if (ex_j_q == pivot_q[RB-1:0]) begin
            ik_dist_d = sum;
            ik_inf_d  = 1'b0;
          end
        end
        if (j_q < n_q) begin
          ex_vld_d = 1'b1;
          ex_j_d   = j_q[RB-1:0];
          j_d      = j_q + CW'(1);
        end else if (i_q + CW'(1) < n_q) begin
          i_d     = i_q + CW'(1);
          state_d = StPassIk;
        end else begin
          state_d = StResp;
        end
      end
      StRdWait: begin
        if (rd_ok_q) begin
          res_dist_d = OutDistW'(a_dist);
          res_inf_d  = a_inf;
          res_pred_d = rdata_a[PosPred +: PredW];
          res_nil_d  = rdata_a[0];
        end
        state_d = StResp;
      end
      StResp: begin
        if (!out_vld_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_vld_d = (out_vld_q && !out_ready_i) || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      out_vld_q <= 1'b0;
      ex_vld_q <= 1'b0;
      ik_ld_q  <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      n_q      <= '0;
    end else begin
      state_q  <= state_d;
      out_vld_q <= out_vld_d;
      ex_vld_q <= ex_vld_d;
      ik_ld_q  <= ik_ld_d;
      i_q      <= i_d;
      j_q      <= j_d;
      n_q      <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ex_j_q     <= ex_j_d;
    rd_ok_q    <= rd_ok_d;
    ik_dist_q  <= ik_dist_d;
    ik_inf_q   <= ik_inf_d;
    res_dist_q <= res_dist_d;
    res_inf_q  <= res_inf_d;
    res_pred_q <= res_pred_d;
    res_nil_q  <= res_nil_d;
    res_cnt_q  <= res_cnt_d;
    if (out_load) begin
      out_dist_q <= res_dist_q;
      out_inf_q  <= res_inf_q;
      out_pred_q <= res_pred_q;
      out_nil_q  <= res_nil_q;
      out_cnt_q  <= res_cnt_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign dist_out_o       = out_dist_q;
  assign dist_inf_out_o   = out_inf_q;
  assign pred_out_o       = out_pred_q;
  assign pred_nil_out_o   = out_nil_q;
  assign improved_count_o = out_cnt_q;

endmodule

// ===== rtl/spr_mem.sv =====
module spr_mem #(
  parameter int unsigned AW = 6,
  parameter int unsigned EW = 21
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [EW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [EW-1:0] rdata_a_o,
  output logic [EW-1:0] rdata_b_o
);

  localparam int unsigned Depth = 1 << AW;

  logic [EW-1:0] mem_q [Depth];
  logic [EW-1:0] rdata_a_q;
  logic [EW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/spr_alu.sv =====
module spr_alu #(
  parameter int unsigned DW = 16
) (
  input  logic signed [DW-1:0] ik_dist_i,
  input  logic                 ik_inf_i,
  input  logic signed [DW-1:0] kj_dist_i,
  input  logic                 kj_inf_i,
  input  logic signed [DW-1:0] ij_dist_i,
  input  logic                 ij_inf_i,
  output logic                 improve_o,
  output logic signed [DW-1:0] sum_o
);

  logic signed [DW:0] sum_ext;
  logic               ovf;

  assign sum_ext   = {ik_dist_i[DW-1], ik_dist_i} + {kj_dist_i[DW-1], kj_dist_i};
  assign ovf       = sum_ext[DW] ^ sum_ext[DW-1];
  assign sum_o     = sum_ext[DW-1:0];
  assign improve_o = !ik_inf_i && !kj_inf_i && !ovf && (ij_inf_i || (sum_o < ij_dist_i));

endmodule

// ===== rtl/spr_checker.sv =====
module spr_checker #(
  parameter int unsigned VERTICES = spr_pkg::VerticesDef
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         func_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] dist_out_o,
  input logic               dist_inf_out_o,
  input logic [2:0]         pred_out_o,
  input logic               pred_nil_out_o,
  input logic [6:0]         improved_count_o
);

  import spr_pkg::*;

  localparam logic [CntW-1:0] CntMax = CntW'(VERTICES * VERTICES);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(dist_out_o)
      && $stable(improved_count_o) && $stable(pred_out_o))
    else $error("result word dropped or changed while stalled");

  a_pass_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (func_i == FuncPass) |=> !in_ready_o)
    else $error("input taken while a pass is in work");

  a_pass_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (improved_count_o != '0) |-> (dist_out_o == '0) && !dist_inf_out_o
      && (pred_out_o == '0) && !pred_nil_out_o)
    else $error("pass result carries entry fields");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> improved_count_o <= CntMax)
    else $error("improved count above entry count");

endmodule

bind shortest_path_pivot_relax spr_checker #(.VERTICES(VERTICES)) u_spr_checker (.*);
